// File: hdl/cte_pkg.sv
// Package: shared constants, payload types and controller/datapath command types.
`timescale 1ns / 1ps

package cte_pkg;

	// Timer rate of the capture counter
	localparam longint unsigned TIMER_HZ = 64'd1000000;

	// Field widths
	localparam int CAP_W   = 16;
	localparam int RPM_W   = 26;
	localparam int ALPHA_W = 9;
	localparam int PPR_W   = 8;
	localparam int MS_W    = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_Q8       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_REV = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS     = 2'd2;

	localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 9'd64;
	localparam logic [PPR_W-1:0]   PPR_RESET     = 8'd7;
	localparam logic [MS_W-1:0]    TIMEOUT_RESET = 16'd300;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 9'd256;

	// Input commands
	localparam logic CMD_CAPTURE = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	// Divider: constant dividend 60 * TIMER_HZ over pulses_per_rev * interval
	localparam longint unsigned RPM_DIVIDEND = 64'd60 * TIMER_HZ;
	localparam int DIV_W   = $clog2(RPM_DIVIDEND + 64'd1);
	localparam int DVSR_W  = PPR_W + CAP_W;
	localparam int DCNT_W  = $clog2(DIV_W);
	localparam logic [DIV_W-1:0]  DIVIDEND_VAL = DIV_W'(RPM_DIVIDEND);
	localparam logic [DCNT_W-1:0] DCNT_LAST    = DCNT_W'(DIV_W - 1);
	localparam logic [RPM_W-1:0]  RPM_MAX      = 26'd60000000;

	localparam int PROD_W = ALPHA_W + RPM_W;

	typedef struct packed {
		logic             command;
		logic [CAP_W-1:0] capture_value;
	} in_item_t;

	typedef struct packed {
		logic [RPM_W-1:0] rpm;
		logic [RPM_W-1:0] filtered_rpm;
		logic             updated;
		logic             stopped;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;    // take the input item
		logic tick;      // millisecond tick update
		logic prime;     // first capture: store only
		logic mul;       // form divisor, start division
		logic div_step;  // one quotient bit
		logic div_end;   // saturate and commit speed
		logic mix_prod;  // averaging products
		logic mix_sum;   // averaging sum
		logic load_out;  // load output register
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_tick;
		logic primed;
	} dp_status_t;

endpackage

// File: hdl/cte_in_if.sv
// Interface: input item channel.
`timescale 1ns / 1ps

interface cte_in_if;
	logic              valid;
	logic              ready;
	cte_pkg::in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

// File: hdl/cte_out_if.sv
// Interface: result item channel.
`timescale 1ns / 1ps

interface cte_out_if;
	logic               valid;
	logic               ready;
	cte_pkg::out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

// File: hdl/cte_cfg_if.sv
// Interface: configuration write channel.
`timescale 1ns / 1ps

interface cte_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [cte_pkg::CFG_IDX_W-1:0]    index;
	logic [cte_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/cte_datapath.sv
// Datapath: configuration, speed state, bit-serial divider and averaging.
`timescale 1ns / 1ps

module cte_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cte_pkg::ctl_cmd_t                cmd,
	output cte_pkg::dp_status_t              status,
	input  cte_pkg::in_item_t                in_item,
	input  logic                             cfg_we,
	input  logic [cte_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cte_pkg::CFG_DATA_W-1:0]   cfg_data,
	output cte_pkg::out_item_t               out_item
);

	logic [cte_pkg::ALPHA_W-1:0] alpha_q;
	logic [cte_pkg::PPR_W-1:0]   ppr_q;
	logic [cte_pkg::MS_W-1:0]    timeout_q;

	logic                        primed_q;
	logic [cte_pkg::CAP_W-1:0]   prev_cap_q;
	logic [cte_pkg::MS_W-1:0]    ms_q;
	logic [cte_pkg::RPM_W-1:0]   speed_q;
	logic [cte_pkg::RPM_W-1:0]   smooth_q;
	logic                        updated_q;

	cte_pkg::in_item_t           item_q;

	logic [cte_pkg::DVSR_W-1:0]  dvsr_q;
	logic [cte_pkg::DVSR_W-1:0]  rem_q;
	logic [cte_pkg::DIV_W-1:0]   dvd_q;
	logic [cte_pkg::DIV_W-1:0]   quo_q;
	logic [cte_pkg::PROD_W-1:0]  prod_a_q;
	logic [cte_pkg::PROD_W-1:0]  prod_b_q;
	cte_pkg::out_item_t          out_q;

	logic [cte_pkg::CAP_W-1:0]   interval;
	logic [cte_pkg::DVSR_W:0]    rem_shift;
	logic                        rem_ge;
	logic [cte_pkg::MS_W-1:0]    ms_next;
	logic [cte_pkg::ALPHA_W-1:0] weight;
	logic [cte_pkg::ALPHA_W-1:0] weight_inv;
	logic [cte_pkg::PROD_W:0]    mix_sum;
	logic [cte_pkg::RPM_W-1:0]   quo_sat;

	always_comb begin
		interval   = item_q.capture_value - prev_cap_q;
		rem_shift  = {rem_q, dvd_q[cte_pkg::DIV_W-1]};
		rem_ge     = rem_shift >= {1'b0, dvsr_q};
		ms_next    = (ms_q == {cte_pkg::MS_W{1'b1}}) ? ms_q : ms_q + 1'b1;
		weight     = (alpha_q > cte_pkg::ALPHA_ONE) ? cte_pkg::ALPHA_ONE : alpha_q;
		weight_inv = cte_pkg::ALPHA_ONE - weight;
		mix_sum    = {1'b0, prod_a_q} + {1'b0, prod_b_q};
		if (dvsr_q == '0 || quo_q > cte_pkg::DIV_W'(cte_pkg::RPM_MAX))
			quo_sat = cte_pkg::RPM_MAX;
		else
			quo_sat = cte_pkg::RPM_W'(quo_q);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q   <= cte_pkg::ALPHA_RESET;
			ppr_q     <= cte_pkg::PPR_RESET;
			timeout_q <= cte_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cte_pkg::CFG_ALPHA_Q8:       alpha_q   <= cfg_data[cte_pkg::ALPHA_W-1:0];
				cte_pkg::CFG_PULSES_PER_REV: ppr_q     <= cfg_data[cte_pkg::PPR_W-1:0];
				cte_pkg::CFG_TIMEOUT_MS:     timeout_q <= cfg_data[cte_pkg::MS_W-1:0];
				default: ;
			endcase
		end
	end

	// Measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q   <= 1'b0;
			prev_cap_q <= '0;
			ms_q       <= '0;
			speed_q    <= '0;
			smooth_q   <= '0;
			updated_q  <= 1'b0;
		end else begin
			if (cmd.tick) begin
				ms_q      <= ms_next;
				updated_q <= 1'b0;
				if (ms_next > timeout_q) begin
					speed_q  <= '0;
					smooth_q <= '0;
				end
			end
			if (cmd.prime) begin
				primed_q   <= 1'b1;
				prev_cap_q <= item_q.capture_value;
				smooth_q   <= '0;
				updated_q  <= 1'b0;
			end
			if (cmd.div_end) begin
				speed_q    <= quo_sat;
				prev_cap_q <= item_q.capture_value;
				ms_q       <= '0;
				updated_q  <= 1'b1;
			end
			if (cmd.mix_sum)
				smooth_q <= cte_pkg::RPM_W'(mix_sum >> 8);
		end
	end

	// Working registers: no reset needed
	always_ff @(posedge clk) begin
		if (cmd.accept)
			item_q <= in_item;
		if (cmd.mul) begin
			dvsr_q <= {{cte_pkg::CAP_W{1'b0}}, ppr_q} * {{cte_pkg::PPR_W{1'b0}}, interval};
			rem_q  <= '0;
			dvd_q  <= cte_pkg::DIVIDEND_VAL;
			quo_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? cte_pkg::DVSR_W'(rem_shift - {1'b0, dvsr_q})
			                : cte_pkg::DVSR_W'(rem_shift);
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[cte_pkg::DIV_W-2:0], rem_ge};
		end
		if (cmd.mix_prod) begin
			prod_a_q <= {{cte_pkg::RPM_W{1'b0}}, weight} * {{cte_pkg::ALPHA_W{1'b0}}, speed_q};
			prod_b_q <= {{cte_pkg::RPM_W{1'b0}}, weight_inv}
			            * {{cte_pkg::ALPHA_W{1'b0}}, smooth_q};
		end
		if (cmd.load_out) begin
			out_q.rpm          <= speed_q;
			out_q.filtered_rpm <= smooth_q;
			out_q.updated      <= updated_q;
			out_q.stopped      <= ms_q > timeout_q;
		end
	end

	assign status.is_tick = item_q.command == cte_pkg::CMD_TICK;
	assign status.primed  = primed_q;
	assign out_item       = out_q;

endmodule

// File: hdl/cte_ctrl.sv
// Controller: sequences one item through the datapath and owns both handshakes.
`timescale 1ns / 1ps

module cte_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  cte_pkg::dp_status_t status,
	output cte_pkg::ctl_cmd_t   cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TICK,
		ST_PRIME,
		ST_MUL,
		ST_DIV,
		ST_SAT,
		ST_PROD,
		ST_SUM,
		ST_DONE
	} state_t;

	state_t                     state_q;
	logic [cte_pkg::DCNT_W-1:0] cnt_q;
	logic                       out_valid_q;
	logic                       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.accept   = in_valid && in_ready;
		cmd.tick     = state_q == ST_TICK;
		cmd.prime    = state_q == ST_PRIME;
		cmd.mul      = state_q == ST_MUL;
		cmd.div_step = state_q == ST_DIV;
		cmd.div_end  = state_q == ST_SAT;
		cmd.mix_prod = state_q == ST_PROD;
		cmd.mix_sum  = state_q == ST_SUM;
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result takes the register as the old one leaves
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					priority if (status.is_tick)
						state_q <= ST_TICK;
					else if (!status.primed)
						state_q <= ST_PRIME;
					else
						state_q <= ST_MUL;
				end
				ST_TICK:  state_q <= ST_DONE;
				ST_PRIME: state_q <= ST_DONE;
				ST_MUL: begin
					cnt_q   <= cte_pkg::DCNT_LAST;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= ST_SAT;
				end
				ST_SAT:  state_q <= ST_PROD;
				ST_PROD: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while still held");

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == ST_DECODE)
		else $error("accepted item not decoded");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == '0) |=> state_q == ST_SAT)
		else $error("divider did not finish on last bit");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.tick, cmd.prime, cmd.mul, cmd.div_step, cmd.div_end,
		          cmd.mix_prod, cmd.mix_sum, cmd.load_out}))
		else $error("more than one datapath command at once");

	a_result_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not offered");

endmodule

// File: hdl/capture_tachometer_ema_unit.sv
// Top level: capture tachometer with exponential speed average.
`timescale 1ns / 1ps
//
// Usage
//   sample : input items. command 0 is a capture event carrying the 16-bit
//            1 MHz timer value, command 1 is a one-millisecond tick.
//   result : one item per input item: rpm, filtered_rpm, updated, stopped.
//   cfg    : register writes (0 alpha_q8, 1 pulses_per_rev, 2 timeout_ms),
//            always ready; write only while the block is idle.
// Steps, from the accept to result valid:
//   tick or first capture : decode, update, load
//   measuring capture     : decode, form divisor, then the restoring divider
//                           (one quotient bit per cycle, 26 bits), saturate,
//                           average and load
// One item at a time is in work; the next is taken once the last is loaded.
// The result sits in an output register: sample.ready comes back while a
// finished item still waits there. If the receiver stalls, the next item is
// worked on and holds in its last step until the register is taken.
// Reset (arst_n low) restores the register defaults (64, 7, 300), clears
// the speed state and forgets the first capture; no clearing pass.

module capture_tachometer_ema_unit (
	input  logic       clk,
	input  logic       arst_n,
	cte_in_if.sink     sample,
	cte_out_if.source  result,
	cte_cfg_if.sink    cfg
);

	cte_pkg::ctl_cmd_t   cmd;
	cte_pkg::dp_status_t status;

	// Configuration never stalls
	assign cfg.ready = 1'b1;

	cte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	cte_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_item   (sample.item),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.out_item  (result.item)
	);

endmodule

// File: sim/tb.sv
// Testbench for capture_tachometer_ema_unit: checks each result against a predictor.
`timescale 1ns / 1ps

module tb;

	// Clocking and limits
	localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer on any channel
	localparam int TAIL_CYCLES    = 40;     // longest latency plus margin
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_ITEMS    = 125;

	// Spare register slot: the block must ignore it
	localparam logic [cte_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	localparam logic [cte_pkg::ALPHA_W-1:0] ALPHA_FULL = 9'd256;
	localparam logic [cte_pkg::RPM_W-1:0]   SPEED_CEIL = 26'd60000000;
	localparam logic [63:0]                 SPEED_NUM  = 64'd60 * cte_pkg::TIMER_HZ;
	localparam logic [cte_pkg::MS_W-1:0]    MS_FULL    = 16'hFFFF;

	logic clk;
	logic arst_n;

	cte_in_if  sample ();
	cte_out_if result ();
	cte_cfg_if cfg ();

	capture_tachometer_ema_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result),
		.cfg    (cfg)
	);

	// Predictor copy of the registers
	logic [cte_pkg::ALPHA_W-1:0] r_alpha;
	logic [cte_pkg::PPR_W-1:0]   r_ppr;
	logic [cte_pkg::MS_W-1:0]    r_timeout;

	// Predictor copy of the speed state
	logic                      m_primed;
	logic [cte_pkg::CAP_W-1:0] m_last_capture;
	logic [cte_pkg::MS_W-1:0]  m_ms_count;
	logic [cte_pkg::RPM_W-1:0] m_speed;
	logic [cte_pkg::RPM_W-1:0] m_speed_avg;

	cte_pkg::out_item_t expected_readings[$];
	int                 errors = 0;
	int                 idle_cycles = 0;

	// Traffic shaping
	bit          tx_gaps_en = 1'b1;
	bit          rx_stall_en = 1'b1;
	int          burst_left = 0;
	int          rx_hold = 0;
	logic [15:0] rx_cycle = '0;

	// Stimulus timer, advanced by each capture_after, so captures form plausible intervals
	logic [cte_pkg::CAP_W-1:0] cap_clock = '0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Next reading after one item; updates the predictor state.
	function automatic cte_pkg::out_item_t tach_predict(input cte_pkg::in_item_t it);
		cte_pkg::out_item_t          r;
		logic [cte_pkg::CAP_W-1:0]   interval;
		logic [cte_pkg::ALPHA_W-1:0] weight;
		logic [63:0]                 divisor;
		logic [63:0]                 quotient;
		logic [63:0]                 mix;
		r = '0;
		if (it.command == cte_pkg::CMD_CAPTURE) begin
			if (!m_primed) begin
				// first capture only arms the interval measurement
				m_primed       = 1'b1;
				m_last_capture = it.capture_value;
				m_speed_avg    = '0;
			end else begin
				interval = it.capture_value - m_last_capture;   // wraps mod 2^16
				weight   = (r_alpha > ALPHA_FULL) ? ALPHA_FULL : r_alpha;
				divisor  = 64'(r_ppr) * 64'(interval);
				if (divisor == 64'd0) begin
					m_speed = SPEED_CEIL;
				end else begin
					quotient = SPEED_NUM / divisor;
					m_speed  = (quotient > 64'(SPEED_CEIL)) ? SPEED_CEIL
						: quotient[cte_pkg::RPM_W-1:0];
				end
				mix = 64'(weight) * 64'(m_speed)
					+ 64'(ALPHA_FULL - weight) * 64'(m_speed_avg);
				m_speed_avg    = mix[cte_pkg::RPM_W+7:8];
				m_last_capture = it.capture_value;
				m_ms_count     = '0;
				r.updated      = 1'b1;
			end
		end else begin
			if (m_ms_count != MS_FULL)
				m_ms_count = m_ms_count + 1'b1;
			if (m_ms_count > r_timeout) begin
				m_speed     = '0;
				m_speed_avg = '0;
			end
		end
		r.rpm          = m_speed;
		r.filtered_rpm = m_speed_avg;
		r.stopped      = (m_ms_count > r_timeout);
		return r;
	endfunction

	// Offer one item; waits for the accept, then queues the predicted reading.
	task automatic send_sample(input logic command, input logic [cte_pkg::CAP_W-1:0] value);
		cte_pkg::in_item_t it;
		int                gap;
		it.command       = command;
		it.capture_value = value;
		if (tx_gaps_en) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 16);
				sample.valid <= 1'b0;
				repeat (gap) @(posedge clk);
				// now and then a long burst with no gaps at all
				burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
			end
			burst_left--;
		end
		sample.valid <= 1'b1;
		sample.item  <= it;
		@(posedge clk);
		while (!sample.ready) @(posedge clk);
		expected_readings.push_back(tach_predict(it));
	endtask

	task automatic send_capture(input logic [cte_pkg::CAP_W-1:0] value);
		send_sample(cte_pkg::CMD_CAPTURE, value);
	endtask

	task automatic send_tick();
		send_sample(cte_pkg::CMD_TICK,
			logic'($urandom_range(0, 1)) ? 16'($urandom) : 16'h0000);
	endtask

	// Capture after a given interval on the stimulus timer
	task automatic capture_after(input logic [cte_pkg::CAP_W-1:0] interval);
		cap_clock = cap_clock + interval;
		send_capture(cap_clock);
	endtask

	// Stop offering and wait until every queued reading has come back
	task automatic drain();
		sample.valid <= 1'b0;
		while (expected_readings.size() != 0) @(posedge clk);
	endtask

	// Register write; only called with nothing in flight
	task automatic write_reg(input logic [cte_pkg::CFG_IDX_W-1:0] idx,
			input logic [cte_pkg::CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			cte_pkg::CFG_ALPHA_Q8:       r_alpha   = data[cte_pkg::ALPHA_W-1:0];
			cte_pkg::CFG_PULSES_PER_REV: r_ppr     = data[cte_pkg::PPR_W-1:0];
			cte_pkg::CFG_TIMEOUT_MS:     r_timeout = data[cte_pkg::MS_W-1:0];
			default: ;
		endcase
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Upper data bits carry junk on the narrow registers: they must be dropped
	task automatic set_alpha(input int unsigned a);
		write_reg(cte_pkg::CFG_ALPHA_Q8, {7'($urandom), 9'(a)});
	endtask

	task automatic set_ppr(input int unsigned p);
		write_reg(cte_pkg::CFG_PULSES_PER_REV, {8'($urandom), 8'(p)});
	endtask

	task automatic set_timeout(input int unsigned t);
		write_reg(cte_pkg::CFG_TIMEOUT_MS, 16'(t));
	endtask

	task automatic report_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		errors++;
		$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
	endtask

	// Result side: every accepted reading is compared with the oldest prediction
	always @(posedge clk) begin
		cte_pkg::out_item_t want;
		if (result.valid && result.ready) begin
			if (expected_readings.size() == 0) begin
				errors++;
				$display("%0t ns: reading with none pending, expected nothing, got rpm %0d",
					$time, result.item.rpm);
			end else begin
				want = expected_readings.pop_front();
				if (result.item.rpm !== want.rpm)
					report_field("rpm", want.rpm, result.item.rpm);
				if (result.item.filtered_rpm !== want.filtered_rpm)
					report_field("filtered_rpm", want.filtered_rpm, result.item.filtered_rpm);
				if (result.item.updated !== want.updated)
					report_field("updated", want.updated, result.item.updated);
				if (result.item.stopped !== want.stopped)
					report_field("stopped", want.stopped, result.item.stopped);
			end
		end
	end

	// Receiver back-pressure: random stalls, with a quiet window whenever rx_cycle[9:7] is all ones
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1'b1;
		if (!rx_stall_en || rx_cycle[9:7] == 3'b111) begin
			result.ready <= 1'b1;
		end else if (rx_hold != 0) begin
			result.ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else begin
			result.ready <= 1'b1;
			if ($urandom_range(0, 5) == 0)
				rx_hold <= $urandom_range(1, 24);
		end
	end

	// Watchdog: too long with nothing moving on any channel
	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("capture_tachometer_ema_unit: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Defaults after reset, ticks ahead of the first capture (timing out too),
	// the arming capture, equal values and the wrap of the 16-bit timer.
	task automatic test_power_up();
		send_tick();
		send_tick();
		drain();
		set_timeout(1);
		send_tick();            // count 3 > 1: stopped before any capture
		send_tick();
		drain();
		set_timeout(300);
		send_capture(16'h1234); // arms only; the speed is left alone
		send_capture(16'h1234 + 16'd1000);
		send_capture(16'h1234 + 16'd1000);   // no interval: speed pinned at the ceiling
		send_capture(16'hFFFF);
		send_capture(16'h0000); // wraps to an interval of one
		drain();
		cap_clock = 16'h0000;
	endtask

	// Register extremes: zero weight, full weight, weight above 256,
	// zero pulses per rev, and the spare register slot.
	task automatic test_register_extremes();
		set_alpha(0);
		set_ppr(1);
		capture_after(16'd1);
		capture_after(16'hFFFF);
		drain();
		set_alpha(256);
		set_ppr(255);
		capture_after(16'd1);
		capture_after(16'd3);
		drain();
		set_alpha(511);
		set_ppr(0);
		capture_after(16'd500);
		capture_after(16'd7);
		drain();
		write_reg(CFG_SPARE, 16'($urandom));
		set_alpha(1);
		set_ppr(1);
		capture_after(16'd2000);
		capture_after(16'd60);
		drain();
	endtask

	// Timeout fires, keeps zeroing, and a measuring capture clears it
	task automatic test_timeout();
		set_timeout(1);
		send_tick();
		send_tick();
		send_tick();
		capture_after(16'd900);
		send_tick();
		send_tick();
		drain();
	endtask

	// Top timeout value: a run of ticks never reaches it, then the value one
	// below the top with a tick and a capture.
	task automatic test_counter_saturation();
		tx_gaps_en  = 1'b0;
		rx_stall_en = 1'b0;
		set_timeout(65535);
		capture_after(16'd1234);
		repeat (40) send_tick();
		drain();
		set_timeout(65534);
		send_tick();
		capture_after(16'd4321);
		drain();
		tx_gaps_en  = 1'b1;
		rx_stall_en = 1'b1;
	endtask

	// Random register setting for one phase, extremes weighted in
	task automatic random_settings(input int phase);
		int unsigned a;
		int unsigned p;
		int unsigned t;
		case ($urandom_range(0, 5))
			0: a = 0;
			1: a = 256;
			2: a = $urandom_range(257, 511);
			default: a = $urandom_range(1, 255);
		endcase
		case ($urandom_range(0, 5))
			0: p = 0;
			1: p = 1;
			2: p = 255;
			default: p = $urandom_range(2, 32);
		endcase
		case ($urandom_range(0, 5))
			0: t = 1;
			1: t = 65535;
			2: t = $urandom;
			default: t = $urandom_range(2, 40);
		endcase
		// order of the writes varies by phase
		if (phase[0]) begin
			set_timeout(t);
			set_ppr(p);
			set_alpha(a);
		end else begin
			set_alpha(a);
			set_ppr(p);
			set_timeout(t);
		end
	endtask

	// Mostly captures at plausible intervals with runs of ticks between,
	// some noise captures with arbitrary timer values.
	task automatic random_phase(input int phase);
		int sent;
		int run;
		sent = 0;
		random_settings(phase);
		while (sent < PHASE_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					run = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 50)
						: $urandom_range(1, 4);
					repeat (run) send_tick();
					sent += run;
				end
				3: begin
					cap_clock = 16'($urandom);
					send_capture(cap_clock);
					sent++;
				end
				4:  begin capture_after(16'd0); sent++; end
				5:  begin capture_after(16'($urandom_range(1, 8))); sent++; end
				6:  begin capture_after(16'($urandom_range(1000, 65535))); sent++; end
				default: begin capture_after(16'($urandom_range(9, 999))); sent++; end
			endcase
			// pause now and then until everything has come back
			if ($urandom_range(0, 59) == 0)
				drain();
		end
		drain();
	endtask

	initial begin
		// predictor at reset defaults
		r_alpha        = cte_pkg::ALPHA_RESET;
		r_ppr          = cte_pkg::PPR_RESET;
		r_timeout      = cte_pkg::TIMEOUT_RESET;
		m_primed       = 1'b0;
		m_last_capture = '0;
		m_ms_count     = '0;
		m_speed        = '0;
		m_speed_avg    = '0;

		arst_n       <= 1'b0;
		sample.valid <= 1'b0;
		sample.item  <= '0;
		cfg.valid    <= 1'b0;
		cfg.index    <= '0;
		cfg.data     <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_up();
		test_register_extremes();
		test_timeout();
		test_counter_saturation();
		for (int ph = 0; ph < RANDOM_PHASES; ph++)
			random_phase(ph);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && expected_readings.size() == 0)
			$display("capture_tachometer_ema_unit: match");
		else
			$display("capture_tachometer_ema_unit: mismatch");
		$finish;
	end

endmodule
